### rtl/core/earliest_free_worker_scheduler_top_assert.svh
// Assertion macros for the earliest-free-worker scheduler.
`ifndef EARLIEST_FREE_WORKER_SCHEDULER_TOP_ASSERT_SVH
`define EARLIEST_FREE_WORKER_SCHEDULER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define EFWS_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Check that cons holds in the cycle after ante.
`define EFWS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`else

`define EFWS_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons)
`define EFWS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

### rtl/core/efws_pkg.sv
// Shared types and constants of the earliest-free-worker scheduler.
`timescale 1ns / 1ps

package efws_pkg;

  localparam int DUR_W           = 32;
  localparam int TIME_W          = 48;
  localparam int IDX_OUT_W       = 4;
  localparam int CNT_W           = 5;
  localparam int MAX_WORKERS_DEF = 16;
  localparam int CNT_CMP_W       = 9;

  localparam logic [CNT_W-1:0]  CNT_RESET = 5'd16;
  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRITE
  } seq_state_t;

  typedef struct packed {
    logic load_job;
    logic rd_en;
    logic cmp_en;
    logic cmp_first;
    logic commit;
  } efws_ctrl_t;

endpackage

### rtl/core/efws_time_mem.sv
// Free-time store: one read and one write port, registered read, valid bits.
`timescale 1ns / 1ps

module efws_time_mem #(
  parameter int DEPTH = efws_pkg::MAX_WORKERS_DEF,
  parameter int IDX_W = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [IDX_W-1:0]          rd_addr,
  output logic [efws_pkg::TIME_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_addr,
  input  logic [efws_pkg::TIME_W-1:0] wr_data
);

  logic [efws_pkg::TIME_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            vld_r;
  logic [efws_pkg::TIME_W-1:0] rd_word_r;
  logic                        rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // An entry never written reads as time zero.
  assign rd_data = rd_vld_r ? rd_word_r : '0;

endmodule

### rtl/core/efws_min_unit.sv
// Shared compare unit: track earliest free worker, form saturated new free time.
`timescale 1ns / 1ps

module efws_min_unit #(
  parameter int IDX_W = 4
) (
  input  logic                        clk,
  input  efws_pkg::efws_ctrl_t        ctrl,
  input  logic [IDX_W-1:0]            cmp_idx,
  input  logic [efws_pkg::TIME_W-1:0] rd_data,
  input  logic [efws_pkg::DUR_W-1:0]  job_duration,
  output logic [IDX_W-1:0]            best_idx,
  output logic [efws_pkg::TIME_W-1:0] best_time,
  output logic [efws_pkg::TIME_W-1:0] new_time
);

  logic [efws_pkg::DUR_W-1:0]  dur_r;
  logic [IDX_W-1:0]            best_idx_r;
  logic [efws_pkg::TIME_W-1:0] best_time_r;
  logic [efws_pkg::TIME_W:0]   sum;

  always_ff @(posedge clk) begin
    if (ctrl.load_job) begin
      dur_r <= job_duration;
    end
    // strict less-than keeps the lowest index on ties
    if (ctrl.cmp_en && (ctrl.cmp_first || (rd_data < best_time_r))) begin
      best_idx_r  <= cmp_idx;
      best_time_r <= rd_data;
    end
  end

  assign sum = {1'b0, best_time_r} +
               {{(efws_pkg::TIME_W + 1 - efws_pkg::DUR_W){1'b0}}, dur_r};

  assign new_time  = sum[efws_pkg::TIME_W] ? efws_pkg::TIME_MAX
                                           : sum[efws_pkg::TIME_W-1:0];
  assign best_idx  = best_idx_r;
  assign best_time = best_time_r;

endmodule

### rtl/core/efws_seq.sv
// Sequencer: walk the active workers through the shared compare unit.
`timescale 1ns / 1ps

module efws_seq #(
  parameter int IDX_W = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IDX_W-1:0]     last_idx,
  input  logic                 out_busy,
  output logic [IDX_W-1:0]     rd_addr,
  output logic [IDX_W-1:0]     cmp_idx,
  output efws_pkg::efws_ctrl_t ctrl
);

  efws_pkg::seq_state_t state_r, state_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 pend_r;
  logic                 pend_first_r;
  logic [IDX_W-1:0]     pend_idx_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      efws_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = efws_pkg::ST_SCAN;
      end
      efws_pkg::ST_SCAN: begin
        if (rd_idx_r == last_idx) state_nxt = efws_pkg::ST_LAST;
      end
      efws_pkg::ST_LAST: begin
        state_nxt = efws_pkg::ST_WRITE;
      end
      efws_pkg::ST_WRITE: begin
        if (!out_busy) state_nxt = efws_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = efws_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    ctrl.load_job  = 1'b0;
    ctrl.rd_en     = 1'b0;
    ctrl.commit    = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    case (state_r)
      efws_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        ctrl.load_job = in_valid;
        rd_idx_nxt    = '0;
      end
      efws_pkg::ST_SCAN: begin
        ctrl.rd_en = 1'b1;
        rd_idx_nxt = rd_idx_r + 1'b1;
      end
      efws_pkg::ST_WRITE: begin
        ctrl.commit = !out_busy;
      end
      default: begin
        rd_idx_nxt = rd_idx_r;
      end
    endcase
    ctrl.cmp_en    = pend_r;
    ctrl.cmp_first = pend_first_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efws_pkg::ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= ctrl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    pend_idx_r   <= rd_idx_r;
    pend_first_r <= (rd_idx_r == '0);
  end

  assign rd_addr = rd_idx_r;
  assign cmp_idx = pend_idx_r;

endmodule

### rtl/core/earliest_free_worker_scheduler_top.sv
// Top level of the earliest-free-worker job scheduler.
`timescale 1ns / 1ps

// Each input word carries a job duration; the block picks the active worker
// with the smallest next-free time (lowest worker number on ties), returns that
// worker and its start time, and advances the worker's free time by the
// duration, saturating at 2^48-1. All free times read as zero after reset
// through per-entry valid bits, so there is no clearing pass. worker_count
// (cfg port) selects workers 0..n-1; zero counts as one, values above
// MAX_WORKERS count as MAX_WORKERS. One job occupies the block through these
// steps in order: accept, read the free-time table through its single read
// port into the shared comparator, finish the last compare, and write back
// and load the result register. The input is not ready during that time; a
// finished result sits in the output register and the next job may be
// accepted while it waits. The write-back step of that next job holds for as
// long as the previous result word is still unread.

`include "earliest_free_worker_scheduler_top_assert.svh"

module earliest_free_worker_scheduler_top #(
  parameter int MAX_WORKERS = efws_pkg::MAX_WORKERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: worker_count
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] job_duration
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [3:0] worker_index, [51:4] start_time, [55:52] zero
);

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam logic [efws_pkg::CNT_CMP_W-1:0] MAX_CNT = efws_pkg::CNT_CMP_W'(MAX_WORKERS);

  efws_pkg::efws_ctrl_t ctrl;

  logic [efws_pkg::CNT_W-1:0]     worker_count_r;
  logic [efws_pkg::CNT_CMP_W-1:0] cnt_ext;
  logic [efws_pkg::CNT_CMP_W-1:0] last_ext;
  logic [IDX_W-1:0]               last_idx;
  logic [IDX_W-1:0]               rd_addr;
  logic [IDX_W-1:0]               cmp_idx;
  logic [IDX_W-1:0]               best_idx;
  logic [efws_pkg::TIME_W-1:0]    rd_data;
  logic [efws_pkg::TIME_W-1:0]    best_time;
  logic [efws_pkg::TIME_W-1:0]    new_time;
  logic [IDX_W+efws_pkg::IDX_OUT_W-1:0] idx_ext;
  logic                           out_busy;

  logic                              out_vld_r;
  logic [efws_pkg::IDX_OUT_W-1:0]    out_idx_r;
  logic [efws_pkg::TIME_W-1:0]       out_time_r;

  // Hold the worker count; the user is to write it only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worker_count_r <= efws_pkg::CNT_RESET;
    end else if (cfg_wr_en) begin
      worker_count_r <= cfg_wr_data;
    end
  end

  // Clamp the count to 1..MAX_WORKERS and turn it into the last index scanned.
  assign cnt_ext = {{(efws_pkg::CNT_CMP_W - efws_pkg::CNT_W){1'b0}}, worker_count_r};

  always_comb begin
    if (cnt_ext == '0) begin
      last_ext = '0;
    end else if (cnt_ext > MAX_CNT) begin
      last_ext = MAX_CNT - 1'b1;
    end else begin
      last_ext = cnt_ext - 1'b1;
    end
  end

  assign last_idx = last_ext[IDX_W-1:0];

  // A result still waiting blocks the write-back step only.
  assign out_busy = out_vld_r && !out_tready;

  efws_seq #(
    .IDX_W (IDX_W)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .last_idx (last_idx),
    .out_busy (out_busy),
    .rd_addr  (rd_addr),
    .cmp_idx  (cmp_idx),
    .ctrl     (ctrl)
  );

  efws_time_mem #(
    .DEPTH (MAX_WORKERS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ctrl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (ctrl.commit),
    .wr_addr (best_idx),
    .wr_data (new_time)
  );

  efws_min_unit #(
    .IDX_W (IDX_W)
  ) u_min (
    .clk          (clk),
    .ctrl         (ctrl),
    .cmp_idx      (cmp_idx),
    .rd_data      (rd_data),
    .job_duration (in_tdata),
    .best_idx     (best_idx),
    .best_time    (best_time),
    .new_time     (new_time)
  );

  // The reported index keeps its low four bits.
  assign idx_ext = {{efws_pkg::IDX_OUT_W{1'b0}}, best_idx};

  // Result register: load on write-back, drop once the word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ctrl.commit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_idx_r  <= idx_ext[efws_pkg::IDX_OUT_W-1:0];
      out_time_r <= best_time;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_time_r, out_idx_r};

  // A job blocks the input until its write-back is done.
  `EFWS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // Write-back always leaves a valid result word.
  `EFWS_ASSERT_NEXT(a_commit_loads_out, clk, rst_n, ctrl.commit, out_tvalid)
  // The chosen worker lies inside the active range.
  `EFWS_ASSERT_SAME(a_best_in_range, clk, rst_n, ctrl.commit, best_idx <= last_idx)

endmodule

### tb/tb_earliest_free_worker_scheduler_top.sv
// Self-checking testbench for the earliest-free-worker job scheduler.
`timescale 1ns / 1ps

module tb_earliest_free_worker_scheduler_top;
  import efws_pkg::*;

  // Longest correct quiet spell is one job at full width or the settle
  // hold-off ahead of a register write; this is far beyond both.
  localparam int STALL_LIMIT   = 2000;
  // Long enough for the slowest job, at n = 16, to finish, with some margin.
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 8;
  localparam int PHASE_JOBS    = 110;
  localparam int PLAN_LEN      = 26;
  localparam int BURST_JOBS    = 16;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;

  // One dispatch decision: which worker and when it starts.
  typedef struct packed {
    logic [IDX_OUT_W-1:0] worker;
    logic [TIME_W-1:0]    start;
  } assignment_t;

  // Directed step: either a worker_count write or a job. Where the outcome
  // is obvious, the expected dispatch is typed in and checked as written.
  typedef struct packed {
    logic                 is_cfg;
    logic [CNT_W-1:0]     crew;
    logic [DUR_W-1:0]     dur;
    logic                 typed;
    logic [IDX_OUT_W-1:0] worker;
    logic [TIME_W-1:0]    start;
  } plan_row_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;   // [31:0] job_duration
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [55:0] out_tdata;          // [3:0] worker_index, [51:4] start_time, [55:52] zero

  // Shadow of the block: free time per worker and the active worker count.
  logic [TIME_W-1:0] free_at [MAX_WORKERS_DEF];
  logic [CNT_W-1:0]  crew_size;

  // Dispatches still owed by the block, oldest first.
  assignment_t pending_q [$];

  int mismatches   = 0;
  int stall_cycles = 0;
  // While set, neither side inserts idle cycles.
  bit calm = 1'b0;

  // Rows 0..6 run at the reset count of sixteen: a full-scale job on worker
  // 0, zero-length jobs that leave worker 1 tied at zero, then fill-ins.
  // Later rows cover a count of one, zero (treated as one), 31 (clamped to
  // sixteen), two, sixteen and three.
  plan_row_t plan [PLAN_LEN] = '{
    '{1'b0, 5'd0,  32'hFFFF_FFFF, 1'b1, 4'd0, 48'h0},
    '{1'b0, 5'd0,  32'h0000_0000, 1'b1, 4'd1, 48'h0},
    '{1'b0, 5'd0,  32'h0000_0000, 1'b1, 4'd1, 48'h0},
    '{1'b0, 5'd0,  32'h0000_0005, 1'b1, 4'd1, 48'h0},
    '{1'b0, 5'd0,  32'h0000_0001, 1'b1, 4'd2, 48'h0},
    '{1'b0, 5'd0,  32'h8000_0000, 1'b1, 4'd3, 48'h0},
    '{1'b0, 5'd0,  32'h0000_0001, 1'b1, 4'd4, 48'h0},
    '{1'b1, 5'd1,  32'h0,         1'b0, 4'd0, 48'h0},
    '{1'b0, 5'd0,  32'hAAAA_AAAA, 1'b1, 4'd0, 48'h0000_FFFF_FFFF},
    '{1'b0, 5'd0,  32'h5555_5555, 1'b1, 4'd0, 48'h0001_AAAA_AAA9},
    '{1'b1, 5'd0,  32'h0,         1'b0, 4'd0, 48'h0},
    '{1'b0, 5'd0,  32'h0000_0007, 1'b0, 4'd0, 48'h0},
    '{1'b1, 5'd31, 32'h0,         1'b0, 4'd0, 48'h0},
    '{1'b0, 5'd0,  32'h0000_0003, 1'b1, 4'd5, 48'h0},
    '{1'b1, 5'd2,  32'h0,         1'b0, 4'd0, 48'h0},
    '{1'b0, 5'd0,  32'h0000_000A, 1'b1, 4'd1, 48'h5},
    '{1'b1, 5'd16, 32'h0,         1'b0, 4'd0, 48'h0},
    '{1'b0, 5'd0,  32'hDEAD_BEEF, 1'b0, 4'd0, 48'h0},
    '{1'b0, 5'd0,  32'h1234_5678, 1'b0, 4'd0, 48'h0},
    '{1'b0, 5'd0,  32'h0000_FFFF, 1'b0, 4'd0, 48'h0},
    '{1'b0, 5'd0,  32'hFFFF_0000, 1'b0, 4'd0, 48'h0},
    '{1'b0, 5'd0,  32'h0000_0002, 1'b0, 4'd0, 48'h0},
    '{1'b1, 5'd3,  32'h0,         1'b0, 4'd0, 48'h0},
    '{1'b0, 5'd0,  32'h7FFF_FFFF, 1'b0, 4'd0, 48'h0},
    '{1'b0, 5'd0,  32'h0000_0000, 1'b0, 4'd0, 48'h0},
    '{1'b0, 5'd0,  32'h0000_0000, 1'b0, 4'd0, 48'h0}
  };

  earliest_free_worker_scheduler_top #(
    .MAX_WORKERS(MAX_WORKERS_DEF)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pick the earliest-free active worker (lowest index wins a tie), then
  // advance its free time by the duration, clamping at the top of the range.
  function automatic assignment_t assign_job(input logic [DUR_W-1:0] dur);
    int                active;
    int                best;
    logic [TIME_W:0]   sum;
    assignment_t       pick;
    if (crew_size == 0) begin
      active = 1;
    end else if (crew_size > MAX_WORKERS_DEF) begin
      active = MAX_WORKERS_DEF;
    end else begin
      active = int'(crew_size);
    end
    best = 0;
    for (int w = 1; w < active; w++) begin
      if (free_at[w] < free_at[best]) best = w;
    end
    pick.worker   = best[IDX_OUT_W-1:0];
    pick.start    = free_at[best];
    sum           = {1'b0, free_at[best]} + {{(TIME_W+1-DUR_W){1'b0}}, dur};
    free_at[best] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    return pick;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t ns", what, got, want, $time);
    mismatches++;
  endtask

  // Drop valid and hold until every owed dispatch has come back; optionally
  // also wait out a full job latency so the block is surely idle.
  task automatic settle_pipeline(input bit holdoff);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    if (holdoff) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write worker_count while the block is idle and mirror it in the shadow.
  task automatic program_crew(input logic [CNT_W-1:0] crew);
    settle_pipeline(1'b1);
    cfg_wr_data <= crew;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    crew_size    = crew;
  endtask

  // Offer one job word, hold it until accepted, then record what it owes.
  // Called and returns at a falling edge.
  task automatic send_job(input logic [DUR_W-1:0] dur, input logic typed,
                          input assignment_t typed_want);
    assignment_t predicted;
    if (!calm) begin
      while ($urandom_range(0, 99) < 26) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= dur;
    do @(posedge clk); while (!in_tready);
    // The shadow advances even for typed rows so later rows stay in step.
    predicted = assign_job(dur);
    pending_q.push_back(typed ? typed_want : predicted);
    @(negedge clk);
  endtask

  // Short jobs often, so workers interleave and tie, with extremes, full
  // random words and single-bit words mixed in.
  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DUR_MAX;
      2, 3, 4: return DUR_W'($urandom_range(0, 1000));
      5, 6:    return $urandom;
      7:       return $urandom & $urandom;
      8:       return $urandom | $urandom;
      default: return DUR_W'(1) << $urandom_range(0, DUR_W - 1);
    endcase
  endfunction

  // Result side: stall about a quarter of the cycles unless calm.
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 26);
  end

  // Compare each accepted result word against the oldest owed dispatch.
  always @(posedge clk) begin : result_check
    assignment_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("result word with nothing pending", 64'(out_tdata), 64'd0);
      end else begin
        want = pending_q.pop_front();
        if (out_tdata[3:0] !== want.worker)
          report_mismatch("worker_index", 64'(out_tdata[3:0]), 64'(want.worker));
        if (out_tdata[51:4] !== want.start)
          report_mismatch("start_time", 64'(out_tdata[51:4]), 64'(want.start));
        if (out_tdata[55:52] !== 4'd0)
          report_mismatch("pad bits", 64'(out_tdata[55:52]), 64'd0);
      end
    end
  end

  // Watchdog: end the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0] phase_crew [PHASES];

    foreach (free_at[w]) free_at[w] = '0;
    crew_size = CNT_RESET;

    // Hold reset, then release it at a falling edge.
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk through the plan table.
    for (int r = 0; r < PLAN_LEN; r++) begin
      if (plan[r].is_cfg) begin
        program_crew(plan[r].crew);
      end else begin
        send_job(plan[r].dur, plan[r].typed,
                 assignment_t'{plan[r].worker, plan[r].start});
      end
    end

    // Random phases, each at its own worker count: full width, one, zero,
    // a clamped value and a few random counts. Phase 6 runs with no idling.
    phase_crew = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd0, 5'd0, 5'd16, 5'd0};
    phase_crew[4] = CNT_W'($urandom_range(2, 15));
    phase_crew[5] = CNT_W'($urandom_range(0, 31));
    phase_crew[7] = CNT_W'($urandom_range(1, 16));
    for (int p = 0; p < PHASES; p++) begin
      program_crew(phase_crew[p]);
      calm = (p == 6);
      for (int k = 0; k < PHASE_JOBS; k++) begin
        // Mid-phase, let the block run completely dry once.
        if (p == 3 && k == PHASE_JOBS / 2) settle_pipeline(1'b0);
        send_job(pick_duration(), 1'b0, '0);
      end
    end

    // With a single active worker, push a back-to-back burst of full-scale
    // jobs so worker 0 runs far ahead of the rest.
    program_crew(5'd1);
    calm = 1'b1;
    for (int j = 0; j < BURST_JOBS; j++) send_job(DUR_MAX, 1'b0, '0);
    calm = 1'b0;

    // Worker 0 lies far ahead, so the others must now take the jobs.
    program_crew(5'd2);
    for (int k = 0; k < 12; k++) send_job(pick_duration(), 1'b0, '0);
    program_crew(5'd16);
    for (int k = 0; k < 30; k++) send_job(pick_duration(), 1'b0, '0);

    // Wait for every owed result, then a latency's worth of quiet so a
    // stray extra word would still be caught.
    settle_pipeline(1'b0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_q.size() != 0)
      report_mismatch("dispatches never returned", 64'(pending_q.size()), 64'd0);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
